// ===== rtl/ffba_pkg.sv =====
package ffba_pkg;

  // Map word geometry: one data word covers WORD_BITS object numbers, one summary
  // word covers WORD_BITS data words.
  localparam int unsigned WORD_BITS = 16;
  localparam int unsigned BIT_W     = 4;
  localparam int unsigned NUM_W     = 12;
  localparam int unsigned STAT_W    = 2;

  localparam logic [WORD_BITS-1:0] WORD_FULL = {WORD_BITS{1'b1}};

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd2;
  localparam logic [STAT_W-1:0] STATUS_FREED = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_A_SUM,
    ST_A_DAT,
    ST_F_RD,
    ST_COMMIT
  } ffba_state_e;

endpackage

// ===== rtl/ffba_ram.sv =====
module ffba_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== rtl/first_free_bitmap_allocator.sv =====
// First-fit allocator of object numbers over a used-bit map held in RAM. Bit 0 is
// reserved, so number 0 is never granted. An allocate request (opcode 0) returns
// the lowest free number if it does not exceed object_count, else status 1 (full).
// A free request (opcode 1) returns status 2 for a number outside 1..object_count
// or beyond the map, status 3 if the number is already free, else clears it. The
// map sits in a data RAM of 16-bit words and a summary RAM with one "word full"
// bit per data word; a search pointer marks the lowest summary word that may have
// room. Rate: one request at a time. An allocation reads the summary word at the
// search pointer and steps the pointer over each full summary word; at a word
// with room it reads the data word and enters write-back. One that runs off the
// end of the summary, or is taken with the pointer already past the end, goes to
// write-back with status 1. A free reads the data and summary words, then enters
// write-back; a rejected free goes straight there. Both RAMs have registered reads
// and updates are a read-modify-write sequence. The result sits in an output
// register, so the next request is taken while it waits; write-back of that next
// request holds until the output register is free. After reset a clearing pass
// over every data word initialises the RAMs, with in_stall_o high; configuration
// writes are taken throughout.
module first_free_bitmap_allocator
  import ffba_pkg::*;
#(
  parameter int unsigned MAP_BITS = 4096
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [NUM_W-1:0]  cfg_object_count_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              opcode_i,
  input  logic [NUM_W-1:0]  free_number_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [NUM_W-1:0]  granted_number_o,
  output logic [STAT_W-1:0] status_o
);

  localparam int unsigned DATA_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned SUM_WORDS  = (DATA_WORDS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned DAW = DATA_WORDS > 1 ? $clog2(DATA_WORDS) : 1;
  localparam int unsigned SAW = SUM_WORDS > 1 ? $clog2(SUM_WORDS) : 1;

  // Lowest clear bit of a map word; callers guarantee one exists.
  function automatic logic [BIT_W-1:0] lowest_clear(input logic [WORD_BITS-1:0] w);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!w[i]) begin
        r = BIT_W'(i);
      end
    end
    return r;
  endfunction

  // Control state
  ffba_state_e      state_q, state_d;
  logic [DAW-1:0]   clr_q, clr_d;
  logic [SAW:0]     hint_q, hint_d;
  logic             out_valid_q, out_valid_d;
  logic [NUM_W-1:0] obj_count_q, obj_count_d;
  logic             dwe_q, dwe_d;
  logic             swe_q, swe_d;
  logic             lower_q, lower_d;

  // Payload state
  logic [DAW-1:0]       word_q, word_d;
  logic [SAW-1:0]       grp_q, grp_d;
  logic [BIT_W-1:0]     sbit_q, sbit_d;
  logic [BIT_W-1:0]     cbit_q, cbit_d;
  logic [WORD_BITS-1:0] sum_q, sum_d;
  logic [WORD_BITS-1:0] dwdata_q, dwdata_d;
  logic [WORD_BITS-1:0] swdata_q, swdata_d;
  logic [NUM_W-1:0]     res_num_q, res_num_d;
  logic [STAT_W-1:0]    res_stat_q, res_stat_d;
  logic [NUM_W-1:0]     out_num_q, out_num_d;
  logic [STAT_W-1:0]    out_stat_q, out_stat_d;

  // RAM ports
  logic                 dram_we, dram_re, sram_we, sram_re;
  logic [DAW-1:0]       dram_waddr, dram_raddr;
  logic [SAW-1:0]       sram_waddr, sram_raddr;
  logic [WORD_BITS-1:0] dram_wdata, dram_rdata, sram_wdata, sram_rdata;

  // Decoded conditions
  logic                 in_acc, free_ok, hint_full, hint_next_full, sum_full;
  logic                 clr_last, clr_in_sum, can_commit, alloc_fits, fbit_set;
  logic [SAW:0]         hint_inc;
  logic [SAW-1:0]       hint_idx;
  logic [BIT_W-1:0]     low_b, low_c;
  logic [31:0]          num32, word32, alloc_num32, base32;
  logic [DAW-1:0]       found_word, free_word;
  logic [SAW-1:0]       free_grp;
  logic [WORD_BITS-1:0] dinit, sinit, dset_word;

  assign cfg_ready_o      = 1'b1;
  assign out_valid_o      = out_valid_q;
  assign granted_number_o = out_num_q;
  assign status_o         = out_stat_q;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign num32      = 32'(free_number_i);
  assign free_ok    = (free_number_i != '0) && (free_number_i <= obj_count_q) &&
                      (num32 < MAP_BITS);
  assign free_word  = num32[DAW+BIT_W-1:BIT_W];
  assign free_grp   = num32[SAW+2*BIT_W-1:2*BIT_W];

  assign hint_idx       = hint_q[SAW-1:0];
  assign hint_inc       = hint_q + 1'b1;
  assign hint_full      = 32'(hint_q) == SUM_WORDS;
  assign hint_next_full = 32'(hint_inc) == SUM_WORDS;

  assign sum_full   = sram_rdata == WORD_FULL;
  assign low_b      = lowest_clear(sram_rdata);
  assign word32     = (32'(hint_idx) << BIT_W) | 32'(low_b);
  assign found_word = word32[DAW-1:0];

  assign low_c       = lowest_clear(dram_rdata);
  assign alloc_num32 = (32'(word_q) << BIT_W) | 32'(low_c);
  assign alloc_fits  = alloc_num32 <= 32'(obj_count_q);
  assign dset_word   = dram_rdata | (WORD_BITS'(1) << low_c);
  assign fbit_set    = dram_rdata[cbit_q];

  assign can_commit = !out_valid_q || !out_stall_i;

  // Clearing pass: data words get the reserved bit and the bits past the map set;
  // summary words mark nonexistent data words as full.
  assign base32     = 32'(clr_q) << BIT_W;
  assign clr_last   = 32'(clr_q) == DATA_WORDS - 1;
  assign clr_in_sum = 32'(clr_q) < SUM_WORDS;

  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      dinit[j] = ((base32 + 32'(j)) >= MAP_BITS) || ((base32 + 32'(j)) == 32'd0);
      sinit[j] = (base32 + 32'(j)) >= DATA_WORDS;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (opcode_i == OP_ALLOC) begin
            state_d = hint_full ? ST_COMMIT : ST_A_SUM;
          end else begin
            state_d = free_ok ? ST_F_RD : ST_COMMIT;
          end
        end
      end
      ST_A_SUM: begin
        if (!sum_full) state_d = ST_A_DAT;
        else if (hint_next_full) state_d = ST_COMMIT;
      end
      ST_A_DAT: state_d = ST_COMMIT;
      ST_F_RD:  state_d = ST_COMMIT;
      ST_COMMIT: begin
        if (can_commit) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // Outputs: handshake and RAM controls
  always_comb begin
    in_stall_o = state_q != ST_IDLE;
    dram_re    = 1'b0;
    dram_raddr = free_word;
    sram_re    = 1'b0;
    sram_raddr = hint_idx;
    dram_we    = 1'b0;
    dram_waddr = word_q;
    dram_wdata = dwdata_q;
    sram_we    = 1'b0;
    sram_waddr = grp_q;
    sram_wdata = swdata_q;
    unique case (state_q)
      ST_CLEAR: begin
        dram_we    = 1'b1;
        dram_waddr = clr_q;
        dram_wdata = dinit;
        sram_we    = clr_in_sum;
        sram_waddr = clr_q[SAW-1:0];
        sram_wdata = sinit;
      end
      ST_IDLE: begin
        if (in_acc && opcode_i == OP_ALLOC && !hint_full) begin
          sram_re = 1'b1;
        end
        if (in_acc && opcode_i == OP_FREE && free_ok) begin
          dram_re    = 1'b1;
          sram_re    = 1'b1;
          sram_raddr = free_grp;
        end
      end
      ST_A_SUM: begin
        if (sum_full && !hint_next_full) begin
          sram_re    = 1'b1;
          sram_raddr = hint_inc[SAW-1:0];
        end
        if (!sum_full) begin
          dram_re    = 1'b1;
          dram_raddr = found_word;
        end
      end
      ST_COMMIT: begin
        dram_we = can_commit && dwe_q;
        sram_we = can_commit && swe_q;
      end
      default: ;
    endcase
  end

  // Datapath next values
  always_comb begin
    clr_d       = clr_q;
    hint_d      = hint_q;
    out_valid_d = out_valid_q && out_stall_i;
    obj_count_d = (cfg_valid_i && cfg_ready_o) ? cfg_object_count_i : obj_count_q;
    dwe_d       = dwe_q;
    swe_d       = swe_q;
    lower_d     = lower_q;
    word_d      = word_q;
    grp_d       = grp_q;
    sbit_d      = sbit_q;
    cbit_d      = cbit_q;
    sum_d       = sum_q;
    dwdata_d    = dwdata_q;
    swdata_d    = swdata_q;
    res_num_d   = res_num_q;
    res_stat_d  = res_stat_q;
    out_num_d   = out_num_q;
    out_stat_d  = out_stat_q;
    unique case (state_q)
      ST_CLEAR: clr_d = clr_q + 1'b1;
      ST_IDLE: begin
        if (in_acc) begin
          // Default outcome: nothing granted, nothing written
          res_num_d  = '0;
          dwe_d      = 1'b0;
          swe_d      = 1'b0;
          lower_d    = 1'b0;
          res_stat_d = opcode_i == OP_ALLOC ? STATUS_FULL : STATUS_RANGE;
          word_d     = free_word;
          grp_d      = free_grp;
          sbit_d     = num32[2*BIT_W-1:BIT_W];
          cbit_d     = num32[BIT_W-1:0];
        end
      end
      ST_A_SUM: begin
        if (sum_full) begin
          // Advance past a full summary word
          hint_d = hint_inc;
        end else begin
          sbit_d = low_b;
          grp_d  = hint_idx;
          word_d = found_word;
          sum_d  = sram_rdata;
        end
      end
      ST_A_DAT: begin
        if (alloc_fits) begin
          res_num_d  = alloc_num32[NUM_W-1:0];
          res_stat_d = STATUS_OK;
          dwe_d      = 1'b1;
          dwdata_d   = dset_word;
          swe_d      = dset_word == WORD_FULL;
          swdata_d   = sum_q | (WORD_BITS'(1) << sbit_q);
        end
      end
      ST_F_RD: begin
        if (fbit_set) begin
          res_stat_d = STATUS_OK;
          dwe_d      = 1'b1;
          dwdata_d   = dram_rdata & ~(WORD_BITS'(1) << cbit_q);
          swe_d      = dram_rdata == WORD_FULL;
          swdata_d   = sram_rdata & ~(WORD_BITS'(1) << sbit_q);
          lower_d    = 1'b1;
        end else begin
          res_stat_d = STATUS_FREED;
        end
      end
      ST_COMMIT: begin
        if (can_commit) begin
          out_valid_d = 1'b1;
          out_num_d   = res_num_q;
          out_stat_d  = res_stat_q;
          // Pull the search pointer back to a group that now has room
          if (lower_q && (32'(grp_q) < 32'(hint_q))) begin
            hint_d = (SAW + 1)'(grp_q);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      hint_q      <= '0;
      out_valid_q <= 1'b0;
      obj_count_q <= NUM_W'(4095);
      dwe_q       <= 1'b0;
      swe_q       <= 1'b0;
      lower_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      hint_q      <= hint_d;
      out_valid_q <= out_valid_d;
      obj_count_q <= obj_count_d;
      dwe_q       <= dwe_d;
      swe_q       <= swe_d;
      lower_q     <= lower_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q     <= word_d;
    grp_q      <= grp_d;
    sbit_q     <= sbit_d;
    cbit_q     <= cbit_d;
    sum_q      <= sum_d;
    dwdata_q   <= dwdata_d;
    swdata_q   <= swdata_d;
    res_num_q  <= res_num_d;
    res_stat_q <= res_stat_d;
    out_num_q  <= out_num_d;
    out_stat_q <= out_stat_d;
  end

  ffba_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(DATA_WORDS)
  ) u_data_ram (
    .clk_i  (clk_i),
    .we_i   (dram_we),
    .waddr_i(dram_waddr),
    .wdata_i(dram_wdata),
    .re_i   (dram_re),
    .raddr_i(dram_raddr),
    .rdata_o(dram_rdata)
  );

  ffba_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(SUM_WORDS)
  ) u_sum_ram (
    .clk_i  (clk_i),
    .we_i   (sram_we),
    .waddr_i(sram_waddr),
    .wdata_i(sram_wdata),
    .re_i   (sram_re),
    .raddr_i(sram_raddr),
    .rdata_o(sram_rdata)
  );

`ifndef NO_ASSERTIONS
  // A granted number is a success within the current limit
  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && granted_number_o != '0) |->
      (status_o == STATUS_OK && granted_number_o <= obj_count_q))
    else $error("granted number with bad status or beyond limit");

  // RAM writes happen only in the clearing pass or at write-back
  a_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dram_we || sram_we) |-> (state_q == ST_CLEAR || state_q == ST_COMMIT))
    else $error("map write outside clear or write-back");

  // Search pointer never runs past the summary
  a_hint_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(hint_q) <= SUM_WORDS)
    else $error("search pointer beyond summary");

  // Summary said the word had room, so the data word must too
  a_sum_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_A_DAT) |-> (dram_rdata != WORD_FULL))
    else $error("summary and data map disagree");

  // Write-back waits while the previous result is still held
  a_commit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMMIT && out_valid_q && out_stall_i) |=>
      (state_q == ST_COMMIT && out_valid_q))
    else $error("write-back overtook a held result");
`endif

endmodule
